// File: hdl/dewd_pkg.sv
// ----------------------------------------------------------------------------
// dewd_pkg
// shared types, codes and constants of the digitizer event word deframer
// ----------------------------------------------------------------------------
package dewd_pkg;

  // number of readout channels on a board
  localparam int CHANNELS = 10;
  // channels that can carry a hit bit in the 10-bit hit pattern
  localparam int HIT_SPAN = (CHANNELS < 10) ? CHANNELS : 10;

  // parse phases
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_EVENT = 2'd1;
  localparam logic [1:0] PH_HITS  = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  // record kinds
  localparam logic [2:0] KIND_HDR_OK   = 3'd0;
  localparam logic [2:0] KIND_HDR_BAD  = 3'd1;
  localparam logic [2:0] KIND_SAMPLE   = 3'd2;
  localparam logic [2:0] KIND_AREA     = 3'd3;
  localparam logic [2:0] KIND_CHAN_ERR = 3'd4;

  // start header sync pattern in the upper half-word
  localparam logic [15:0] SYNC_WORD = 16'hFADC;
  localparam logic [15:0] SKIP_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  held_board;
    logic [25:0] held_event;
    logic [9:0]  held_hits;
    logic [7:0]  words_per_channel;
    logic [3:0]  hits_left;
    logic [3:0]  hit_ordinal;
    logic [7:0]  word_counter;
    logic [15:0] skip_counter;
    logic [7:0]  expected_board;
    logic        board_ok;
  } dewd_state_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  board_number;
    logic [25:0] event_number;
    logic [9:0]  hit_channels;
    logic [9:0]  trigger_channels;
    logic [9:0]  gain_channels;
    logic [15:0] skipped_words;
    logic [31:0] payload_word;
    logic [3:0]  hit_position;
    logic [7:0]  word_position;
    logic        event_end;
    logic        crate_done;
  } dewd_rec_t;

endpackage

// File: hdl/dewd_decode.sv
// ----------------------------------------------------------------------------
// dewd_decode
// one-word parse step: next parser state and the record the word produces
// ----------------------------------------------------------------------------
module dewd_decode (
  input  dewd_pkg::dewd_state_t state,
  input  logic [31:0]           word,
  input  logic [7:0]            board_count,
  output dewd_pkg::dewd_state_t state_nxt,
  output logic                  emit,
  output dewd_pkg::dewd_rec_t   rec
);

  logic [3:0] hit_cnt;
  logic [3:0] chan;
  logic [3:0] hits_dec;
  logic [7:0] board_inc;
  logic       board_match;
  logic       crate_wrap;
  // board bookkeeping applied when the current event ends
  dewd_pkg::dewd_state_t fin;

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < dewd_pkg::HIT_SPAN; i++) begin
      hit_cnt = hit_cnt + 4'(word[i]);
    end
  end

  assign chan        = word[31:28];
  assign hits_dec    = state.hits_left - 4'd1;
  assign board_inc   = state.expected_board + 8'd1;
  assign crate_wrap  = (board_inc >= board_count);
  assign board_match = (state.held_board == state.expected_board);

  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    rec       = '0;
    fin       = state;

    rec.board_number = state.held_board;
    rec.event_number = state.held_event;
    rec.hit_channels = state.held_hits;

    unique case (state.phase)
      dewd_pkg::PH_EVENT: begin
        state_nxt.held_event = word[25:0];
        state_nxt.phase      = dewd_pkg::PH_HITS;
      end

      dewd_pkg::PH_HITS: begin
        emit                   = 1'b1;
        state_nxt.held_hits    = word[9:0];
        state_nxt.board_ok     = board_match;
        state_nxt.skip_counter = '0;
        state_nxt.hits_left    = hit_cnt;
        state_nxt.hit_ordinal  = '0;
        state_nxt.word_counter = '0;
        rec.record_kind      = board_match ? dewd_pkg::KIND_HDR_OK : dewd_pkg::KIND_HDR_BAD;
        rec.hit_channels     = word[9:0];
        rec.trigger_channels = word[19:10];
        rec.gain_channels    = word[29:20];
        rec.skipped_words    = state.skip_counter;
        if (hit_cnt == 4'd0) begin
          // no hits: header closes the event, board_ok is the new one
          rec.event_end   = 1'b1;
          state_nxt.phase = dewd_pkg::PH_HUNT;
          if (board_match) begin
            state_nxt.expected_board = crate_wrap ? 8'd0 : board_inc;
            rec.crate_done           = crate_wrap;
          end
        end else begin
          state_nxt.phase = dewd_pkg::PH_DATA;
        end
      end

      dewd_pkg::PH_DATA: begin
        emit             = 1'b1;
        rec.payload_word = word;
        // end-of-event board update using the held board_ok
        if (state.board_ok) begin
          fin.expected_board = crate_wrap ? 8'd0 : board_inc;
        end
        fin.phase = dewd_pkg::PH_HUNT;
        if (state.word_counter < state.words_per_channel) begin
          rec.record_kind        = dewd_pkg::KIND_SAMPLE;
          rec.hit_position       = state.hit_ordinal;
          rec.word_position      = state.word_counter;
          state_nxt.word_counter = state.word_counter + 8'd1;
        end else if (chan >= 4'(dewd_pkg::CHANNELS)) begin
          rec.record_kind  = dewd_pkg::KIND_CHAN_ERR;
          rec.hit_position = chan;
          rec.event_end    = 1'b1;
          rec.crate_done   = state.board_ok & crate_wrap;
          state_nxt        = fin;
        end else begin
          rec.record_kind  = dewd_pkg::KIND_AREA;
          rec.hit_position = chan;
          if (hits_dec == 4'd0) begin
            rec.event_end = 1'b1;
            rec.crate_done = state.board_ok & crate_wrap;
            state_nxt     = fin;
          end
          state_nxt.word_counter = '0;
          state_nxt.hit_ordinal  = state.hit_ordinal + 4'd1;
          state_nxt.hits_left    = hits_dec;
        end
      end

      default: begin
        // hunting for the start header
        if (word[31:16] == dewd_pkg::SYNC_WORD) begin
          state_nxt.held_board        = word[15:8] - 8'd1;
          state_nxt.words_per_channel = word[7:0];
          state_nxt.phase             = dewd_pkg::PH_EVENT;
        end else begin
          state_nxt.phase = dewd_pkg::PH_HUNT;
          if (state.skip_counter != dewd_pkg::SKIP_MAX) begin
            state_nxt.skip_counter = state.skip_counter + 16'd1;
          end
        end
      end
    endcase
  end

endmodule

// File: hdl/digitizer_event_word_deframer.sv
// ----------------------------------------------------------------------------
// digitizer_event_word_deframer
// syncs on digitizer start headers and turns the stream into event records
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall  | in_stream_word (32 bits)
//  out_    | output    | out_valid/out_stall| out_record_kind ... out_crate_done
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data (board_count, 8 bits)
//
//  one word per cycle sustained while out_ is not stalled: an input register
//  feeds the parse logic, which updates the parser state and the result register
//  together, and a parsed word's record is shown on out_ from the result register
//  start, event and skipped words give no record and leave nothing on out_
//  out_stall holds the result register and, through it, the input register
//  synchronous active-low reset returns to sync hunting with board_count = 1
//
module digitizer_event_word_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_stream_word,
  // result request channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_record_kind,
  output logic [7:0]  out_board_number,
  output logic [25:0] out_event_number,
  output logic [9:0]  out_hit_channels,
  output logic [9:0]  out_trigger_channels,
  output logic [9:0]  out_gain_channels,
  output logic [15:0] out_skipped_words,
  output logic [31:0] out_payload_word,
  output logic [3:0]  out_hit_position,
  output logic [7:0]  out_word_position,
  output logic        out_event_end,
  output logic        out_crate_done,
  // board count register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  // input register
  logic        in_vld_r;
  logic [31:0] word_r;
  // parser state and configuration
  dewd_pkg::dewd_state_t state_r;
  dewd_pkg::dewd_state_t state_nxt;
  logic [7:0]            board_count_r;
  // result register
  logic                out_vld_r;
  dewd_pkg::dewd_rec_t rec_r;
  dewd_pkg::dewd_rec_t rec_nxt;
  logic                emit;
  // handshake
  logic out_free;
  logic step;

  // result register is free when empty or being taken this cycle
  assign out_free = !out_vld_r || !out_stall;
  // the held word is parsed when the result side can take its record
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  dewd_decode u_decode (
    .state       (state_r),
    .word        (word_r),
    .board_count (board_count_r),
    .state_nxt   (state_nxt),
    .emit        (emit),
    .rec         (rec_nxt)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_count_r <= 8'd1;
    end else if (cfg_wr_en) begin
      board_count_r <= cfg_wr_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      word_r <= in_stream_word;
    end
  end

  // parser state advances once per parsed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all-zero state is sync hunting with cleared counters
      state_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_record_kind      = rec_r.record_kind;
  assign out_board_number     = rec_r.board_number;
  assign out_event_number     = rec_r.event_number;
  assign out_hit_channels     = rec_r.hit_channels;
  assign out_trigger_channels = rec_r.trigger_channels;
  assign out_gain_channels    = rec_r.gain_channels;
  assign out_skipped_words    = rec_r.skipped_words;
  assign out_payload_word     = rec_r.payload_word;
  assign out_hit_position     = rec_r.hit_position;
  assign out_word_position    = rec_r.word_position;
  assign out_event_end        = rec_r.event_end;
  assign out_crate_done       = rec_r.crate_done;

`ifndef NO_ASSERTIONS
  // crate completion only ever rides on an event end
  a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crate_done |-> out_event_end)
    else $error("crate_done without event_end");

  // sample words never close an event
  a_sample_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == dewd_pkg::KIND_SAMPLE) |-> !out_event_end)
    else $error("sample record marked as event end");

  // a channel error carries an out-of-range channel
  a_err_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == dewd_pkg::KIND_CHAN_ERR)
      |-> (out_hit_position >= 4'(dewd_pkg::CHANNELS)) && out_event_end)
    else $error("channel error with valid channel");

  // skip count is only reported on header records
  a_skip_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind != dewd_pkg::KIND_HDR_OK)
      && (out_record_kind != dewd_pkg::KIND_HDR_BAD) |-> (out_skipped_words == 16'd0))
    else $error("skip count on non-header record");

  // the parser only advances when the result side can take a record
  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(state_r))
    else $error("parser state moved while results stalled");
`endif

endmodule
